@@ rtl/ppl_pkg.sv @@
// ----------------------------------------------------------------------------
// Positional path loss engine package
// Word types, codes, constants and sequencer states shared by the engine.
// ----------------------------------------------------------------------------
package ppl_pkg;

    localparam int NODES   = 16;
    localparam int NODE_AW = $clog2(NODES);

    localparam logic [2:0] KIND_ENABLE  = 3'd0;
    localparam logic [2:0] KIND_DISABLE = 3'd1;
    localparam logic [2:0] KIND_SET     = 3'd2;
    localparam logic [2:0] KIND_MOVE    = 3'd3;
    localparam logic [2:0] KIND_QUERY   = 3'd4;

    localparam logic [2:0] STATUS_OK      = 3'd0;
    localparam logic [2:0] STATUS_UNKNOWN = 3'd1;
    localparam logic [2:0] STATUS_LATE    = 3'd2;
    localparam logic [2:0] STATUS_NO_POS  = 3'd3;
    localparam logic [2:0] STATUS_BAD     = 3'd4;

    localparam logic [1:0] REG_EXPONENT = 2'd0;
    localparam logic [1:0] REG_NO_POS   = 2'd1;
    localparam logic [1:0] REG_EXTRA    = 2'd2;

    localparam logic [10:0] EXPONENT_RESET = 11'd512;
    localparam logic [15:0] NO_POS_RESET   = 16'd15360;
    localparam logic [15:0] EXTRA_RESET    = 16'd0;

    localparam logic [17:0] LOSS_MAX      = 18'd262143;
    localparam logic [17:0] LOSS_DISABLED = 18'd256000;
    localparam logic [20:0] LOSS_FLOOR    = 21'd5120;
    localparam logic [31:0] LOG_SCALE_K   = 32'd1616142483;
    localparam logic signed [36:0] BASE_Q24  = 37'sd664448635;
    localparam logic signed [36:0] FLOOR_Q24 = 37'sd335544320;
    localparam logic [22:0] L_ZERO_DIST_MAG = 23'd1966080;
    localparam logic signed [22:0] LOG2_OFFSET = 23'sd1048576;

    typedef logic signed [23:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_pos;

    typedef struct packed {
        logic [63:0] start_time;
        logic [63:0] end_time;
        t_pos        start_pos;
        t_pos        end_pos;
    } t_node_rec;

    typedef struct packed {
        logic [2:0]         kind;
        logic [63:0]        event_time;
        logic [7:0]         node;
        logic [7:0]         peer_node;
        logic signed [23:0] target_x;
        logic signed [23:0] target_y;
        logic signed [23:0] target_z;
        logic [31:0]        move_duration;
    } t_in_word;

    typedef struct packed {
        logic [17:0] loss;
        logic [2:0]  status;
    } t_out_word;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_RD,
        S_INTERP,
        S_AXIS_INIT,
        S_DIV_DBL,
        S_DIV_ADD,
        S_AXIS_END,
        S_NODE_DONE,
        S_SQ,
        S_SQ_ACC,
        S_LOG_START,
        S_NORM,
        S_LOG_INIT,
        S_LOG_MUL,
        S_LOG_UPD,
        S_SCALE_MUL,
        S_SCALE_GET,
        S_EXP_MUL,
        S_EXP_GET,
        S_ROUND,
        S_DONE
    } t_state;

endpackage

@@ rtl/ppl_node_table.sv @@
// ----------------------------------------------------------------------------
// Node trajectory table
// One record per node, one write port and one registered read port.
// ----------------------------------------------------------------------------
module ppl_node_table (
    input  logic                          i_clk,
    input  logic                          i_rd_en,
    input  logic [ppl_pkg::NODE_AW-1:0]   i_rd_addr,
    output ppl_pkg::t_node_rec            o_rd_data,
    input  logic                          i_wr_en,
    input  logic [ppl_pkg::NODE_AW-1:0]   i_wr_addr,
    input  ppl_pkg::t_node_rec            i_wr_data
);

    ppl_pkg::t_node_rec r_mem [ppl_pkg::NODES];
    ppl_pkg::t_node_rec r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd;

endmodule

@@ rtl/ppl_mul.sv @@
// ----------------------------------------------------------------------------
// Shared multiplier
// Registered 32 by 32 bit unsigned multiplier used by the squaring, log2, scaling and exponent steps of a query.
// ----------------------------------------------------------------------------
module ppl_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);

    logic [63:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

@@ rtl/positional_path_loss_engine_top.sv @@
// ----------------------------------------------------------------------------
// Positional path loss engine
// Node table with trajectories and a log-distance path loss sequencer.
// ----------------------------------------------------------------------------
// The input channel takes one word per item (enable, disable, set, move or
// query) and the output channel returns exactly one word per item, holding
// the loss and a status. Both channels use valid and ready. The block works
// on one item at a time: it is ready only when its sequencer is idle, but a
// finished word waiting in the output register does not stop the next item
// from being accepted.
// Enable, disable, set and rejected items go from decode straight to the
// output step. A move or a query interpolates each node it reads with a
// bit-serial divider, a doubling step and an add step per quotient bit. A
// query then runs the squared distance, a six-step normalising shift and
// sixteen squarings of the log2 loop on the shared multiplier.
// Reset enables every node, marks every node as having no position, clears
// the query time and loads the register defaults. If the receiver stalls,
// the finished word is held and the sequencer waits in its last step until
// the word is taken. Configuration is written through a plain write port;
// the user must write it only while idle, the block does not enforce this.
// ----------------------------------------------------------------------------
module positional_path_loss_engine_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ppl_pkg::t_in_word  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ppl_pkg::t_out_word o_out,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    localparam int AW = ppl_pkg::NODE_AW;

    ppl_pkg::t_state    r_state, n_state;
    ppl_pkg::t_in_word  r_item;
    logic [ppl_pkg::NODES-1:0] r_enabled, n_enabled;
    logic [ppl_pkg::NODES-1:0] r_has_pos, n_has_pos;
    logic [63:0]        r_last_qt, n_last_qt;
    logic               r_q_seen, n_q_seen;
    logic [10:0]        r_exp;
    logic [15:0]        r_npl, r_extra;
    ppl_pkg::t_out_word r_res, n_res;
    logic               r_out_valid, n_out_valid;
    ppl_pkg::t_out_word r_out, n_out;
    logic               r_which, n_which;
    logic [1:0]         r_axis, n_axis;
    logic [63:0]        r_el, n_el, r_span, n_span;
    logic [64:0]        r_rem, n_rem;
    logic [24:0]        r_quo, n_quo, r_mag, n_mag;
    logic               r_neg, n_neg;
    logic [4:0]         r_bit, n_bit;
    ppl_pkg::t_coord    r_cur [3];
    ppl_pkg::t_coord    n_cur [3];
    ppl_pkg::t_coord    r_pa [3];
    ppl_pkg::t_coord    n_pa [3];
    ppl_pkg::t_coord    r_pb [3];
    ppl_pkg::t_coord    n_pb [3];
    logic [63:0]        r_w, n_w;
    logic [5:0]         r_e, n_e;
    logic [3:0]         r_cnt, n_cnt;
    logic [31:0]        r_m, n_m;
    logic [21:0]        r_lg, n_lg;
    logic [22:0]        r_lmag, n_lmag;
    logic               r_lneg, n_lneg;
    logic signed [36:0] r_total, n_total;

    logic               rd_en, wr_en;
    logic [AW-1:0]      rd_addr, wr_addr;
    ppl_pkg::t_node_rec wr_data, rec;
    logic [31:0]        mul_a, mul_b;
    logic [63:0]        mul_p;

    logic [AW-1:0]      node_idx, peer_idx;
    logic               node_bad, peer_bad;
    ppl_pkg::t_pos      tgt;
    logic [64:0]        end_sum;
    logic [63:0]        end_sat;
    ppl_pkg::t_coord    ax_start, ax_end;
    logic signed [24:0] ax_d, sq_d;
    logic [64:0]        dbl, add_s;
    logic [6:0]         sh;
    logic signed [22:0] lg_v;
    logic [21:0]        lg_vmag;
    logic [33:0]        exp_prod;
    logic signed [36:0] tot_r;
    logic [20:0]        pl;
    logic [21:0]        pl_sum;

    function automatic ppl_pkg::t_coord axis_of(ppl_pkg::t_pos p, logic [1:0] a);
        ppl_pkg::t_coord c;
        case (a)
            2'd0:    c = p.x;
            2'd1:    c = p.y;
            default: c = p.z;
        endcase
        return c;
    endfunction

    ppl_node_table u_table (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rec),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    ppl_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    assign node_idx = r_item.node[AW-1:0];
    assign peer_idx = r_item.peer_node[AW-1:0];
    assign node_bad = {1'b0, r_item.node} >= 9'(ppl_pkg::NODES);
    assign peer_bad = {1'b0, r_item.peer_node} >= 9'(ppl_pkg::NODES);
    assign tgt      = '{x: r_item.target_x, y: r_item.target_y, z: r_item.target_z};
    assign end_sum  = {1'b0, r_item.event_time} + {33'd0, r_item.move_duration};
    assign end_sat  = end_sum[64] ? '1 : end_sum[63:0];
    assign ax_start = axis_of(rec.start_pos, r_axis);
    assign ax_end   = axis_of(rec.end_pos, r_axis);
    assign ax_d     = {ax_end[23], ax_end} - {ax_start[23], ax_start};
    assign sq_d     = {r_pa[r_axis][23], r_pa[r_axis]} - {r_pb[r_axis][23], r_pb[r_axis]};
    assign dbl      = {r_rem[63:0], 1'b0};
    assign add_s    = r_rem + {1'b0, r_el};
    assign sh       = 7'd32 >> r_cnt[2:0];
    assign lg_v     = $signed({1'b0, r_lg}) - ppl_pkg::LOG2_OFFSET;
    assign lg_vmag  = lg_v[22] ? 22'(-lg_v) : lg_v[21:0];
    assign exp_prod = mul_p[33:0];
    assign tot_r    = r_total + 37'sd32768;
    assign pl       = (r_total < ppl_pkg::FLOOR_Q24) ? ppl_pkg::LOSS_FLOOR : tot_r[36:16];
    assign pl_sum   = {1'b0, pl} + {6'd0, r_extra};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ppl_pkg::S_IDLE;
            r_enabled   <= '1;
            r_has_pos   <= '0;
            r_last_qt   <= '0;
            r_q_seen    <= 1'b0;
            r_out_valid <= 1'b0;
            r_exp       <= ppl_pkg::EXPONENT_RESET;
            r_npl       <= ppl_pkg::NO_POS_RESET;
            r_extra     <= ppl_pkg::EXTRA_RESET;
        end else begin
            r_state     <= n_state;
            r_enabled   <= n_enabled;
            r_has_pos   <= n_has_pos;
            r_last_qt   <= n_last_qt;
            r_q_seen    <= n_q_seen;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    ppl_pkg::REG_EXPONENT: r_exp   <= i_cfg_data[10:0];
                    ppl_pkg::REG_NO_POS:   r_npl   <= i_cfg_data;
                    ppl_pkg::REG_EXTRA:    r_extra <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item <= i_in;
        end
        r_res   <= n_res;
        r_out   <= n_out;
        r_which <= n_which;
        r_axis  <= n_axis;
        r_el    <= n_el;
        r_span  <= n_span;
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_mag   <= n_mag;
        r_neg   <= n_neg;
        r_bit   <= n_bit;
        r_cur   <= n_cur;
        r_pa    <= n_pa;
        r_pb    <= n_pb;
        r_w     <= n_w;
        r_e     <= n_e;
        r_cnt   <= n_cnt;
        r_m     <= n_m;
        r_lg    <= n_lg;
        r_lmag  <= n_lmag;
        r_lneg  <= n_lneg;
        r_total <= n_total;
    end

    always_comb begin
        n_state     = r_state;
        n_enabled   = r_enabled;
        n_has_pos   = r_has_pos;
        n_last_qt   = r_last_qt;
        n_q_seen    = r_q_seen;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        n_which     = r_which;
        n_axis      = r_axis;
        n_el        = r_el;
        n_span      = r_span;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_mag       = r_mag;
        n_neg       = r_neg;
        n_bit       = r_bit;
        n_cur       = r_cur;
        n_pa        = r_pa;
        n_pb        = r_pb;
        n_w         = r_w;
        n_e         = r_e;
        n_cnt       = r_cnt;
        n_m         = r_m;
        n_lg        = r_lg;
        n_lmag      = r_lmag;
        n_lneg      = r_lneg;
        n_total     = r_total;
        rd_en       = 1'b0;
        rd_addr     = r_which ? peer_idx : node_idx;
        wr_en       = 1'b0;
        wr_addr     = node_idx;
        wr_data     = '{start_time: r_item.event_time, end_time: r_item.event_time,
                        start_pos: tgt, end_pos: tgt};
        mul_a       = '0;
        mul_b       = '0;

        unique case (r_state)
            ppl_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = ppl_pkg::S_DECODE;
                end
            end
            ppl_pkg::S_DECODE: begin
                n_res   = '{loss: '0, status: ppl_pkg::STATUS_OK};
                n_state = ppl_pkg::S_DONE;
                n_which = 1'b0;
                if (r_item.kind > ppl_pkg::KIND_QUERY) begin
                    n_res.status = ppl_pkg::STATUS_BAD;
                end else if (r_item.kind == ppl_pkg::KIND_QUERY) begin
                    if (!r_q_seen || r_item.event_time > r_last_qt) begin
                        n_last_qt = r_item.event_time;
                    end
                    n_q_seen = 1'b1;
                    if (node_bad || peer_bad) begin
                        n_res.status = ppl_pkg::STATUS_UNKNOWN;
                    end else if (!r_enabled[node_idx] || !r_enabled[peer_idx]) begin
                        n_res.loss = ppl_pkg::LOSS_DISABLED;
                    end else if (!r_has_pos[node_idx] || !r_has_pos[peer_idx]) begin
                        n_res.loss = 18'({1'b0, r_npl} + {1'b0, r_extra});
                    end else begin
                        n_state = ppl_pkg::S_RD;
                    end
                end else if (r_q_seen && r_item.event_time <= r_last_qt) begin
                    n_res.status = ppl_pkg::STATUS_LATE;
                end else if (node_bad) begin
                    n_res.status = ppl_pkg::STATUS_UNKNOWN;
                end else begin
                    case (r_item.kind)
                        ppl_pkg::KIND_ENABLE:  n_enabled[node_idx] = 1'b1;
                        ppl_pkg::KIND_DISABLE: n_enabled[node_idx] = 1'b0;
                        ppl_pkg::KIND_SET: begin
                            wr_en               = 1'b1;
                            n_has_pos[node_idx] = 1'b1;
                        end
                        default: begin
                            if (!r_has_pos[node_idx]) begin
                                n_res.status = ppl_pkg::STATUS_NO_POS;
                            end else begin
                                n_state = ppl_pkg::S_RD;
                            end
                        end
                    endcase
                end
            end
            ppl_pkg::S_RD: begin
                rd_en   = 1'b1;
                n_state = ppl_pkg::S_INTERP;
            end
            ppl_pkg::S_INTERP: begin
                n_el   = r_item.event_time - rec.start_time;
                n_span = rec.end_time - rec.start_time;
                n_axis = 2'd0;
                if (r_item.event_time >= rec.end_time) begin
                    n_cur   = '{rec.end_pos.x, rec.end_pos.y, rec.end_pos.z};
                    n_state = ppl_pkg::S_NODE_DONE;
                end else if (r_item.event_time <= rec.start_time) begin
                    n_cur   = '{rec.start_pos.x, rec.start_pos.y, rec.start_pos.z};
                    n_state = ppl_pkg::S_NODE_DONE;
                end else begin
                    n_state = ppl_pkg::S_AXIS_INIT;
                end
            end
            ppl_pkg::S_AXIS_INIT: begin
                n_neg   = ax_d[24];
                n_mag   = ax_d[24] ? 25'(-ax_d) : ax_d;
                n_rem   = '0;
                n_quo   = '0;
                n_bit   = 5'd24;
                n_state = ppl_pkg::S_DIV_DBL;
            end
            ppl_pkg::S_DIV_DBL: begin
                if (dbl >= {1'b0, r_span}) begin
                    n_rem = dbl - {1'b0, r_span};
                    n_quo = {r_quo[23:0], 1'b1};
                end else begin
                    n_rem = dbl;
                    n_quo = {r_quo[23:0], 1'b0};
                end
                n_state = ppl_pkg::S_DIV_ADD;
            end
            ppl_pkg::S_DIV_ADD: begin
                if (r_mag[r_bit]) begin
                    if (add_s >= {1'b0, r_span}) begin
                        n_rem = add_s - {1'b0, r_span};
                        n_quo = r_quo + 25'd1;
                    end else begin
                        n_rem = add_s;
                    end
                end
                if (r_bit == 5'd0) begin
                    n_state = ppl_pkg::S_AXIS_END;
                end else begin
                    n_bit   = r_bit - 5'd1;
                    n_state = ppl_pkg::S_DIV_DBL;
                end
            end
            ppl_pkg::S_AXIS_END: begin
                n_cur[r_axis] = r_neg ? ax_start - r_quo[23:0] : ax_start + r_quo[23:0];
                if (r_axis == 2'd2) begin
                    n_state = ppl_pkg::S_NODE_DONE;
                end else begin
                    n_axis  = r_axis + 2'd1;
                    n_state = ppl_pkg::S_AXIS_INIT;
                end
            end
            ppl_pkg::S_NODE_DONE: begin
                if (r_item.kind == ppl_pkg::KIND_MOVE) begin
                    wr_en   = 1'b1;
                    wr_data = '{start_time: r_item.event_time, end_time: end_sat,
                                start_pos: '{x: r_cur[0], y: r_cur[1], z: r_cur[2]},
                                end_pos: tgt};
                    n_state = ppl_pkg::S_DONE;
                end else if (!r_which) begin
                    n_pa    = r_cur;
                    n_which = 1'b1;
                    n_state = ppl_pkg::S_RD;
                end else begin
                    n_pb    = r_cur;
                    n_axis  = 2'd0;
                    n_w     = '0;
                    n_state = ppl_pkg::S_SQ;
                end
            end
            ppl_pkg::S_SQ: begin
                mul_a   = {7'd0, sq_d[24] ? 25'(-sq_d) : sq_d};
                mul_b   = mul_a;
                n_state = ppl_pkg::S_SQ_ACC;
            end
            ppl_pkg::S_SQ_ACC: begin
                n_w = r_w + mul_p;
                if (r_axis == 2'd2) begin
                    n_state = ppl_pkg::S_LOG_START;
                end else begin
                    n_axis  = r_axis + 2'd1;
                    n_state = ppl_pkg::S_SQ;
                end
            end
            ppl_pkg::S_LOG_START: begin
                if (r_w == '0) begin
                    n_lmag  = ppl_pkg::L_ZERO_DIST_MAG;
                    n_lneg  = 1'b1;
                    n_state = ppl_pkg::S_EXP_MUL;
                end else begin
                    n_e     = 6'd63;
                    n_cnt   = 4'd0;
                    n_state = ppl_pkg::S_NORM;
                end
            end
            ppl_pkg::S_NORM: begin
                if ((r_w >> (7'd64 - sh)) == 64'd0) begin
                    n_w = r_w << sh;
                    n_e = r_e - sh[5:0];
                end
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd5) begin
                    n_state = ppl_pkg::S_LOG_INIT;
                end
            end
            ppl_pkg::S_LOG_INIT: begin
                n_m     = r_w[63:32];
                n_lg    = {r_e, 16'd0};
                n_cnt   = 4'd15;
                n_state = ppl_pkg::S_LOG_MUL;
            end
            ppl_pkg::S_LOG_MUL: begin
                mul_a   = r_m;
                mul_b   = r_m;
                n_state = ppl_pkg::S_LOG_UPD;
            end
            ppl_pkg::S_LOG_UPD: begin
                if (mul_p[63]) begin
                    n_lg = r_lg | (22'd1 << r_cnt);
                    n_m  = mul_p[63:32];
                end else begin
                    n_m  = mul_p[62:31];
                end
                if (r_cnt == 4'd0) begin
                    n_state = ppl_pkg::S_SCALE_MUL;
                end else begin
                    n_cnt   = r_cnt - 4'd1;
                    n_state = ppl_pkg::S_LOG_MUL;
                end
            end
            ppl_pkg::S_SCALE_MUL: begin
                mul_a   = {10'd0, lg_vmag};
                mul_b   = ppl_pkg::LOG_SCALE_K;
                n_lneg  = lg_v[22];
                n_state = ppl_pkg::S_SCALE_GET;
            end
            ppl_pkg::S_SCALE_GET: begin
                n_lmag  = mul_p[52:30];
                n_state = ppl_pkg::S_EXP_MUL;
            end
            ppl_pkg::S_EXP_MUL: begin
                mul_a   = {21'd0, r_exp};
                mul_b   = {9'd0, r_lmag};
                n_state = ppl_pkg::S_EXP_GET;
            end
            ppl_pkg::S_EXP_GET: begin
                n_total = r_lneg ? ppl_pkg::BASE_Q24 - $signed({3'd0, exp_prod})
                                 : ppl_pkg::BASE_Q24 + $signed({3'd0, exp_prod});
                n_state = ppl_pkg::S_ROUND;
            end
            ppl_pkg::S_ROUND: begin
                n_res.loss = (pl_sum > {4'd0, ppl_pkg::LOSS_MAX}) ? ppl_pkg::LOSS_MAX
                                                                 : pl_sum[17:0];
                n_state    = ppl_pkg::S_DONE;
            end
            ppl_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = ppl_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ppl_pkg::S_IDLE;
            end
        endcase
    end

    assign o_in_ready  = (r_state == ppl_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("item accepted while the sequencer was busy");

    a_div_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ppl_pkg::S_DIV_DBL || r_state == ppl_pkg::S_DIV_ADD)
        |-> (r_rem < {1'b0, r_span}))
        else $error("divider remainder not below the span");

    a_log_normalised: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ppl_pkg::S_LOG_MUL) |-> r_m[31])
        else $error("log2 mantissa lost its leading one");

    a_error_no_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status != ppl_pkg::STATUS_OK) |-> (o_out.loss == '0))
        else $error("error word carries a loss");

    a_done_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ppl_pkg::S_DONE && r_out_valid && !i_out_ready)
        |=> (r_state == ppl_pkg::S_DONE))
        else $error("finished word overwrote a waiting word");
`endif

endmodule

@@ dv/positional_path_loss_engine_top_tb.sv @@
// ----------------------------------------------------------------------------
// Positional path loss engine testbench
// A short table of directed items runs first, then 630 random items
// over several register settings and idling modes. Each result word is
// compared with a fixed word for some directed items, else with one worked
// out by a model of the node table and the log-distance loss inside this bench.
// ----------------------------------------------------------------------------
module positional_path_loss_engine_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] KIND_BAD_LO = 3'd5;
    localparam logic [2:0] KIND_BAD_HI = 3'd7;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        ppl_pkg::t_in_word  w;
        bit                 typed;
        ppl_pkg::t_out_word want;
    } t_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    ppl_pkg::t_in_word  i_in;
    logic               o_out_valid;
    logic               i_out_ready;
    ppl_pkg::t_out_word o_out;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_index;
    logic [15:0]        i_cfg_data;

    positional_path_loss_engine_top dut (.*);

    logic [10:0] m_exponent;
    logic [15:0] m_no_pos_loss;
    logic [15:0] m_extra_loss;
    bit          m_enabled [ppl_pkg::NODES];
    bit          m_has_pos [ppl_pkg::NODES];
    logic [63:0] m_t_start [ppl_pkg::NODES];
    logic [63:0] m_t_end [ppl_pkg::NODES];
    logic signed [23:0] m_p_start [ppl_pkg::NODES][3];
    logic signed [23:0] m_p_end [ppl_pkg::NODES][3];
    logic [63:0] m_last_query;
    bit          m_query_seen;

    ppl_pkg::t_out_word loss_q[$];
    int          fail_count = 0;
    int          idle_cycles = 0;
    int          send_idle = 0;
    int          recv_stall = 0;
    int          hold_cycles = 0;
    logic [63:0] sim_ticks = 0;
    t_row        rows[$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void node_pos_at(int n, logic [63:0] t,
                                        output logic signed [23:0] p [3]);
        logic [63:0] span, el, mag;
        logic signed [63:0] d;
        if (t >= m_t_end[n]) begin
            p = m_p_end[n];
        end else if (t <= m_t_start[n]) begin
            p = m_p_start[n];
        end else begin
            span = m_t_end[n] - m_t_start[n];
            el = t - m_t_start[n];
            for (int a = 0; a < 3; a++) begin
                d = 64'(m_p_end[n][a]) - 64'(m_p_start[n][a]);
                mag = (d < 0 ? -d : d) * el / span;
                p[a] = 24'(64'(m_p_start[n][a]) + (d < 0 ? -$signed(mag) : $signed(mag)));
            end
        end
    endfunction

    function automatic logic [17:0] loss_from_dist2(logic [63:0] d2);
        logic signed [63:0] l16, total, v;
        logic [63:0] m, mag, pl;
        logic [31:0] r;
        int n;
        if (d2 == '0) begin
            l16 = -64'sd1966080;
        end else begin
            n = 63;
            while (n > 0 && !d2[n]) n--;
            m = (n >= 31) ? d2 >> (n - 31) : d2 << (31 - n);
            r = 32'(n) << 16;
            for (int i = 15; i >= 0; i--) begin
                m = (m * m) >> 31;
                if (m >= 64'h1_0000_0000) begin
                    r[i] = 1'b1;
                    m = m >> 1;
                end
            end
            v = $signed({32'b0, r}) - 64'sd1048576;
            mag = ((v < 0 ? -v : v) * 64'd1616142483) >> 30;
            l16 = v < 0 ? -$signed(mag) : $signed(mag);
        end
        total = 64'sd664448635 + $signed({53'b0, m_exponent}) * l16;
        if (total < (64'sd20 <<< 24)) pl = 64'd5120;
        else pl = (total + 64'sd32768) >> 16;
        pl = pl + 64'(m_extra_loss);
        return pl > 64'd262143 ? ppl_pkg::LOSS_MAX : pl[17:0];
    endfunction

    function automatic ppl_pkg::t_out_word apply_word(ppl_pkg::t_in_word w);
        ppl_pkg::t_out_word res;
        logic signed [23:0] pa [3], pb [3];
        logic signed [63:0] d;
        logic [63:0] d2, sum;
        int n, pr;
        res = '0;
        n = int'(w.node);
        pr = int'(w.peer_node);
        if (w.kind > ppl_pkg::KIND_QUERY) begin
            res.status = ppl_pkg::STATUS_BAD;
        end else if (w.kind == ppl_pkg::KIND_QUERY) begin
            if (!m_query_seen || w.event_time > m_last_query) m_last_query = w.event_time;
            m_query_seen = 1'b1;
            if (n >= ppl_pkg::NODES || pr >= ppl_pkg::NODES) begin
                res.status = ppl_pkg::STATUS_UNKNOWN;
            end else if (!m_enabled[n] || !m_enabled[pr]) begin
                res.loss = ppl_pkg::LOSS_DISABLED;
            end else if (!m_has_pos[n] || !m_has_pos[pr]) begin
                res.loss = 18'(m_no_pos_loss) + 18'(m_extra_loss);
            end else begin
                node_pos_at(n, w.event_time, pa);
                node_pos_at(pr, w.event_time, pb);
                d2 = '0;
                for (int a = 0; a < 3; a++) begin
                    d = 64'(pa[a]) - 64'(pb[a]);
                    d2 = d2 + d * d;
                end
                res.loss = loss_from_dist2(d2);
            end
        end else if (m_query_seen && w.event_time <= m_last_query) begin
            res.status = ppl_pkg::STATUS_LATE;
        end else if (n >= ppl_pkg::NODES) begin
            res.status = ppl_pkg::STATUS_UNKNOWN;
        end else if (w.kind == ppl_pkg::KIND_ENABLE) begin
            m_enabled[n] = 1'b1;
        end else if (w.kind == ppl_pkg::KIND_DISABLE) begin
            m_enabled[n] = 1'b0;
        end else if (w.kind == ppl_pkg::KIND_SET) begin
            m_p_start[n] = '{w.target_x, w.target_y, w.target_z};
            m_p_end[n] = '{w.target_x, w.target_y, w.target_z};
            m_t_start[n] = w.event_time;
            m_t_end[n] = w.event_time;
            m_has_pos[n] = 1'b1;
        end else if (!m_has_pos[n]) begin
            res.status = ppl_pkg::STATUS_NO_POS;
        end else begin
            node_pos_at(n, w.event_time, pa);
            m_p_start[n] = pa;
            m_t_start[n] = w.event_time;
            m_p_end[n] = '{w.target_x, w.target_y, w.target_z};
            sum = w.event_time + 64'(w.move_duration);
            m_t_end[n] = (sum < w.event_time) ? '1 : sum;
        end
        return res;
    endfunction

    task automatic send_word(ppl_pkg::t_in_word w, bit typed, ppl_pkg::t_out_word want);
        ppl_pkg::t_out_word predicted;
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predicted = apply_word(w);
        loss_q.push_back(typed ? want : predicted);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            ppl_pkg::REG_EXPONENT: m_exponent = val[10:0];
            ppl_pkg::REG_NO_POS:   m_no_pos_loss = val;
            ppl_pkg::REG_EXTRA:    m_extra_loss = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (loss_q.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
    endtask

    function automatic logic signed [23:0] rand_coord();
        if ($urandom_range(9) == 0) return 24'($urandom);
        return 24'($signed($urandom_range(4000)) - 2000);
    endfunction

    function automatic ppl_pkg::t_in_word rand_word();
        ppl_pkg::t_in_word w;
        int pick;
        pick = $urandom_range(99);
        w.node = 8'($urandom_range(ppl_pkg::NODES - 1));
        w.peer_node = 8'($urandom_range(ppl_pkg::NODES - 1));
        w.target_x = rand_coord();
        w.target_y = rand_coord();
        w.target_z = rand_coord();
        w.move_duration = ($urandom_range(19) == 0) ? $urandom : $urandom_range(1, 300);
        sim_ticks = sim_ticks + 64'($urandom_range(1, 60));
        w.event_time = sim_ticks;
        if (pick < 38) w.kind = ppl_pkg::KIND_QUERY;
        else if (pick < 55) w.kind = ppl_pkg::KIND_SET;
        else if (pick < 78) w.kind = ppl_pkg::KIND_MOVE;
        else if (pick < 87) w.kind = ppl_pkg::KIND_ENABLE;
        else if (pick < 92) w.kind = ppl_pkg::KIND_DISABLE;
        else if (pick < 94) w.kind = 3'($urandom_range(KIND_BAD_LO, KIND_BAD_HI));
        else if (pick < 97) begin
            w.kind = 3'($urandom_range(ppl_pkg::KIND_ENABLE, ppl_pkg::KIND_QUERY));
            w.node = 8'($urandom_range(ppl_pkg::NODES, 255));
            w.peer_node = 8'($urandom_range(255));
        end else begin
            w.kind = 3'($urandom_range(ppl_pkg::KIND_ENABLE, ppl_pkg::KIND_MOVE));
            w.event_time = m_last_query - 64'($urandom_range(0, 3));
        end
        return w;
    endfunction

    function automatic t_row mk(logic [2:0] k, logic [63:0] t, logic [7:0] n, logic [7:0] p,
                                logic signed [23:0] x, logic signed [23:0] y,
                                logic signed [23:0] z, logic [31:0] dur, bit typed = 1'b0,
                                logic [17:0] loss = '0,
                                logic [2:0] st = ppl_pkg::STATUS_OK);
        t_row r;
        r.w = '{k, t, n, p, x, y, z, dur};
        r.typed = typed;
        r.want = '{loss, st};
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            i_out_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    always @(posedge i_clk) begin
        ppl_pkg::t_out_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (loss_q.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) $display("Unexpected output word %p", o_out);
            end else begin
                want = loss_q.pop_front();
                if (o_out.loss !== want.loss || o_out.status !== want.status) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("Mismatch: expected loss %0d status %0d, got loss %0d status %0d",
                                 want.loss, want.status, o_out.loss, o_out.status);
                end
            end
        end
        if (i_rst_n && !(o_out_valid && i_out_ready) && !(i_in_valid && o_in_ready))
            idle_cycles = idle_cycles + 1;
        else
            idle_cycles = 0;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int stall_pct [4] = '{0, 0, 75, 37};
        int idle_pct [4] = '{0, 75, 0, 37};
        logic [15:0] cfg_set [6][3] = '{
            '{16'd512, 16'd15360, 16'd0},
            '{16'd0, 16'd0, 16'd65535},
            '{16'd2047, 16'd65535, 16'd0},
            '{16'd2047, 16'd100, 16'd300},
            '{16'd300, 16'd15360, 16'd1000},
            '{16'd1024, 16'd65535, 16'd65535}};
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        i_out_ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = ppl_pkg::REG_EXPONENT;
        i_cfg_data = '0;
        m_exponent = ppl_pkg::EXPONENT_RESET;
        m_no_pos_loss = ppl_pkg::NO_POS_RESET;
        m_extra_loss = ppl_pkg::EXTRA_RESET;
        for (int i = 0; i < ppl_pkg::NODES; i++) begin
            m_enabled[i] = 1'b1;
            m_has_pos[i] = 1'b0;
            m_t_start[i] = '0;
            m_t_end[i] = '0;
            m_p_start[i] = '{0, 0, 0};
            m_p_end[i] = '{0, 0, 0};
        end
        m_last_query = '0;
        m_query_seen = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        rows.push_back(mk(ppl_pkg::KIND_QUERY, 0, 0, 1, 0, 0, 0, 0, 1, 18'd15360,
                          ppl_pkg::STATUS_OK));
        rows.push_back(mk(KIND_BAD_LO, 0, 0, 0, 0, 0, 0, 0, 1, 0, ppl_pkg::STATUS_BAD));
        rows.push_back(mk(KIND_BAD_HI, 0, 0, 0, 0, 0, 0, 0, 1, 0, ppl_pkg::STATUS_BAD));
        rows.push_back(mk(ppl_pkg::KIND_QUERY, 1, 0, 200, 0, 0, 0, 0, 1, 0,
                          ppl_pkg::STATUS_UNKNOWN));
        rows.push_back(mk(ppl_pkg::KIND_ENABLE, 5, 16, 0, 0, 0, 0, 0, 1, 0,
                          ppl_pkg::STATUS_UNKNOWN));
        rows.push_back(mk(ppl_pkg::KIND_ENABLE, 1, 3, 0, 0, 0, 0, 0, 1, 0,
                          ppl_pkg::STATUS_LATE));
        rows.push_back(mk(ppl_pkg::KIND_MOVE, 6, 2, 0, 5, 5, 5, 10, 1, 0,
                          ppl_pkg::STATUS_NO_POS));
        rows.push_back(mk(ppl_pkg::KIND_SET, 10, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(ppl_pkg::KIND_SET, 11, 1, 0, 0, 0, 0, 0));
        rows.push_back(mk(ppl_pkg::KIND_QUERY, 12, 0, 1, 0, 0, 0, 0));
        rows.push_back(mk(ppl_pkg::KIND_DISABLE, 13, 1, 0, 0, 0, 0, 0));
        rows.push_back(mk(ppl_pkg::KIND_QUERY, 14, 0, 1, 0, 0, 0, 0, 1,
                          ppl_pkg::LOSS_DISABLED, ppl_pkg::STATUS_OK));
        rows.push_back(mk(ppl_pkg::KIND_ENABLE, 15, 1, 0, 0, 0, 0, 0));
        rows.push_back(mk(ppl_pkg::KIND_SET, 16, 1, 0, 24'sd8388607, 24'sd8388607,
                          24'sd8388607, 0));
        rows.push_back(mk(ppl_pkg::KIND_SET, 17, 0, 0, -24'sd8388608, -24'sd8388608,
                          -24'sd8388608, 0));
        rows.push_back(mk(ppl_pkg::KIND_QUERY, 18, 0, 1, 0, 0, 0, 0));
        rows.push_back(mk(ppl_pkg::KIND_MOVE, 20, 1, 0, 0, 0, 0, 32'hFFFF_FFFF));
        rows.push_back(mk(ppl_pkg::KIND_QUERY, 21, 1, 0, 0, 0, 0, 0));
        rows.push_back(mk(ppl_pkg::KIND_MOVE, 30, 0, 0, 256, 0, 0, 100));
        rows.push_back(mk(ppl_pkg::KIND_QUERY, 80, 0, 1, 0, 0, 0, 0));
        rows.push_back(mk(ppl_pkg::KIND_QUERY, 200, 0, 1, 0, 0, 0, 0));
        rows.push_back(mk(ppl_pkg::KIND_SET, 201, 255, 0, 1, 2, 3, 0, 1, 0,
                          ppl_pkg::STATUS_UNKNOWN));
        rows.push_back(mk(ppl_pkg::KIND_QUERY, 202, 15, 14, 0, 0, 0, 0, 1, 18'd15360,
                          ppl_pkg::STATUS_OK));
        foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].want);
        sim_ticks = 64'd300;
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            write_reg(ppl_pkg::REG_EXPONENT, cfg_set[ph][0]);
            write_reg(ppl_pkg::REG_NO_POS, cfg_set[ph][1]);
            write_reg(ppl_pkg::REG_EXTRA, cfg_set[ph][2]);
            send_idle = idle_pct[ph % 4];
            recv_stall = stall_pct[ph % 4];
            if (ph == 5) sim_ticks = 64'hFFFF_FFFF_FFFF_0000;
            for (int k = 0; k < 105; k++) begin
                if (k == 50 && ph == 1) hold_cycles = 2000;
                if (k == 70 && ph == 2) begin
                    i_in_valid <= 1'b0;
                    @(posedge i_clk);
                    while (loss_q.size() != 0) @(posedge i_clk);
                end
                send_word(rand_word(), 0, '0);
            end
            drain();
        end

        repeat (400) @(posedge i_clk);
        if (fail_count == 0 && loss_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
